// ===== rtl/apsf_pkg.sv =====
package apsf_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FILTER_ORDER = 1'b0,
    CFG_OUTPUT_GAIN  = 1'b1
  } cfg_idx_e;

  // Input item functions
  typedef enum logic [0:0] {
    FUNC_LOAD_COEF = 1'b0,
    FUNC_FILTER    = 1'b1
  } func_e;

  localparam logic [4:0]  ORDER_RESET = 5'd10;
  localparam logic [15:0] GAIN_RESET  = 16'd4096;

  typedef struct packed {
    logic               func;
    logic [4:0]         coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] sample;
    logic               frame_start;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] filtered;
    logic               saturated;
  } out_rsp_t;

endpackage

// ===== rtl/all_pole_synthesis_filter_top.sv =====
// All-pole (LPC synthesis) filter, direct form, fixed point.
// Input channel (in_valid_i / in_stall_o / in_req_i): a request either loads one
// coefficient a[k] (func = 0, no result) or filters one Q1.15 sample (func = 1,
// one result). frame_start on a sample clears the output history first.
// Output channel (out_valid_o / out_stall_i / out_rsp_o): gained, saturated Q1.15
// sample plus a flag set when the recursion or the gain stage clipped.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 sets the filter order,
// index 1 the unsigned Q4.12 gain. Write only while the block is idle.
// A coefficient load is written into its table when it is taken. For a sample,
// taps is the order limited to MAX_ORDER: one shared multiply-accumulate walks
// the taps, one per cycle, fed by the coefficient and history memories (one
// read port each, registered data), followed by the rounding and gain stages.
// One sample is in flight at a time; in_stall_o is high while it is worked on.
// The result sits in an output register; a stalled result holds there and the
// next request is taken meanwhile, but its result waits for that register.
// Reset clears both tables (by per-entry valid bits), the history pointer,
// and loads order 10 and gain 1.0. No clearing pass is needed.
module all_pole_synthesis_filter_top
  import apsf_pkg::*;
#(
  parameter int MAX_ORDER = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  cfg_idx_e cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int PW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int KW    = $clog2(MAX_ORDER + 1);
  localparam int ACC_W = 33 + $clog2(MAX_ORDER + 1);
  localparam logic [PW-1:0] LAST = PW'(MAX_ORDER - 1);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(2048);
  localparam logic signed [ACC_W-1:0] ACC_MAX  = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] ACC_MIN  = -ACC_W'(32768);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_ROUND,
    ST_GAIN,
    ST_FIN
  } state_e;

  state_e   state_q;
  logic [PW-1:0] ptr_q;
  logic [KW-1:0] cnt_q;
  logic     rd_v_q, prod_v_q;
  logic     out_valid_q;
  out_rsp_t out_rsp_q;
  logic [4:0]  order_q;
  logic [15:0] gain_q;

  logic [MAX_ORDER-1:0] coef_vld_q, hist_vld_q;
  logic signed [15:0] coef_mem [MAX_ORDER];
  logic signed [15:0] hist_mem [MAX_ORDER];

  logic signed [15:0] coef_rd_q, hist_rd_q;
  logic               cvld_rd_q, hvld_rd_q;
  logic [PW-1:0]      caddr_q, raddr_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [31:0] prod_q;
  logic signed [15:0] y_q;
  logic               y_clip_q;
  logic signed [32:0] gprod_q;

  logic in_acc, is_load, is_sample, load_ok, rd_en, hist_we, out_free;
  logic [PW-1:0] base_ptr, load_addr;
  logic [KW-1:0] taps;
  logic signed [15:0] coef_tap, hist_tap;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [15:0] y_sat;
  logic               y_clip;
  logic signed [33:0] g_sh;
  logic signed [15:0] o_sat;
  logic               o_clip;

  // Decode the incoming request
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_load     = in_acc && (in_req_i.func == FUNC_LOAD_COEF);
  assign is_sample   = in_acc && (in_req_i.func == FUNC_FILTER);
  assign load_ok     = (in_req_i.coef_index != 5'd0) &&
                       (32'(in_req_i.coef_index) <= MAX_ORDER);
  assign load_addr   = PW'(in_req_i.coef_index - 5'd1);
  assign base_ptr    = in_req_i.frame_start ? '0 : ptr_q;
  assign rd_en       = (state_q == ST_RUN) && (cnt_q != '0);
  assign hist_we     = (state_q == ST_ROUND);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Limit the order to the table depth
  always_comb begin
    if (32'(order_q) > MAX_ORDER) begin
      taps = KW'(MAX_ORDER);
    end else begin
      taps = KW'(order_q);
    end
  end

  // Mask coefficients never written since reset and history never written since reset or frame start
  assign coef_tap = cvld_rd_q ? coef_rd_q : '0;
  assign hist_tap = hvld_rd_q ? hist_rd_q : '0;

  // Round and saturate the recursion output
  always_comb begin
    acc_sh = (acc_q + ACC_HALF) >>> 12;
    y_clip = 1'b1;
    priority if (acc_sh > ACC_MAX) begin
      y_sat = 16'sh7fff;
    end else if (acc_sh < ACC_MIN) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat  = acc_sh[15:0];
      y_clip = 1'b0;
    end
  end

  // Round and saturate the gained output
  always_comb begin
    g_sh   = (34'(gprod_q) + 34'sd2048) >>> 12;
    o_clip = 1'b1;
    priority if (g_sh > 34'sd32767) begin
      o_sat = 16'sh7fff;
    end else if (g_sh < -34'sd32768) begin
      o_sat = -16'sh8000;
    end else begin
      o_sat  = g_sh[15:0];
      o_clip = 1'b0;
    end
  end

  // Sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
      order_q     <= ORDER_RESET;
      gain_q      <= GAIN_RESET;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_FILTER_ORDER: order_q <= cfg_data_i[4:0];
          CFG_OUTPUT_GAIN:  gain_q  <= cfg_data_i;
          default:          ;
        endcase
      end
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      rd_v_q   <= rd_en;
      prod_v_q <= rd_v_q;
      unique case (state_q)
        ST_IDLE: begin
          if (is_sample) begin
            ptr_q   <= base_ptr;
            cnt_q   <= taps;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - KW'(1);
          end else if (!rd_v_q && !prod_v_q) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          ptr_q   <= (ptr_q == LAST) ? '0 : ptr_q + PW'(1);
          state_q <= ST_GAIN;
        end
        ST_GAIN: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q         <= 1'b1;
            out_rsp_q.filtered  <= o_sat;
            out_rsp_q.saturated <= y_clip_q | o_clip;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Entry valid bits: reset clears both, frame start clears the history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      hist_vld_q <= '0;
    end else begin
      if (is_load && load_ok) begin
        coef_vld_q[load_addr] <= 1'b1;
      end
      if (is_sample && in_req_i.frame_start) begin
        hist_vld_q <= '0;
      end else if (hist_we) begin
        hist_vld_q[ptr_q] <= 1'b1;
      end
    end
  end

  // Coefficient and history memories
  always_ff @(posedge clk_i) begin
    if (is_load && load_ok) begin
      coef_mem[load_addr] <= in_req_i.coef_value;
    end
    if (hist_we) begin
      hist_mem[ptr_q] <= y_sat;
    end
    if (rd_en) begin
      coef_rd_q <= coef_mem[caddr_q];
      hist_rd_q <= hist_mem[raddr_q];
      cvld_rd_q <= coef_vld_q[caddr_q];
      hvld_rd_q <= hist_vld_q[raddr_q];
    end
  end

  // Tap walk, multiply-accumulate and gain datapath
  always_ff @(posedge clk_i) begin
    if (is_sample) begin
      acc_q   <= ACC_W'(in_req_i.sample) <<< 12;
      caddr_q <= '0;
      raddr_q <= (base_ptr == '0) ? LAST : base_ptr - PW'(1);
    end else begin
      if (rd_en) begin
        caddr_q <= caddr_q + PW'(1);
        raddr_q <= (raddr_q == '0) ? LAST : raddr_q - PW'(1);
      end
      if (prod_v_q) begin
        acc_q <= acc_q - ACC_W'(prod_q);
      end
    end
    if (rd_v_q) begin
      prod_q <= coef_tap * hist_tap;
    end
    if (hist_we) begin
      y_q      <= y_sat;
      y_clip_q <= y_clip;
    end
    if (state_q == ST_GAIN) begin
      gprod_q <= signed'({1'b0, gain_q}) * y_q;
    end
  end

endmodule

// ===== rtl/apsf_checker.sv =====
module apsf_checker
  import apsf_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input in_req_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_rsp_t out_rsp_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed or dropped");

  // Stall while a sample is being filtered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_req_i.func == FUNC_FILTER) |=> in_stall_o)
    else $error("sample request not followed by stall");

  // A coefficient load yields no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_req_i.func == FUNC_LOAD_COEF) && !out_valid_o |=> !out_valid_o)
    else $error("result appeared after a coefficient load");

  // A sample result does not appear in the cycle after the sample is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_req_i.func == FUNC_FILTER) && !out_valid_o |=> !out_valid_o)
    else $error("result appeared one cycle after a sample");

endmodule

bind all_pole_synthesis_filter_top apsf_checker u_apsf_checker (.*);

// ===== test/all_pole_synthesis_filter_top_tb.sv =====
module all_pole_synthesis_filter_top_tb;
  import apsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ORDER    = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 180;

  // Predicts the filter output for each sample and checks results in order
  class filter_scoreboard;
    logic signed [15:0] coef_tab[MAX_ORDER];
    logic signed [15:0] history[MAX_ORDER];
    logic [3:0]         hist_ptr;
    logic [4:0]         order;
    logic [15:0]        gain;
    out_rsp_t           expected_outputs[$];
    int                 errors;

    function new();
      foreach (coef_tab[i]) coef_tab[i] = '0;
      foreach (history[i]) history[i] = '0;
      hist_ptr = '0;
      order    = ORDER_RESET;
      gain     = GAIN_RESET;
      errors   = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [15:0] data);
      if (idx == CFG_FILTER_ORDER) begin
        order = data[4:0];
      end else begin
        gain = data;
      end
    endfunction

    // floor((v + 2^11) / 2^12)
    function longint round_q12(longint v);
      return (v + 64'sd2048) >>> 12;
    endfunction

    function longint clip16(longint v, inout bit clip);
      if (v > 32767) begin
        clip = 1'b1;
        return 32767;
      end
      if (v < -32768) begin
        clip = 1'b1;
        return -32768;
      end
      return v;
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    function void note_request(in_req_t req);
      longint   acc;
      longint   y;
      longint   o;
      int       taps;
      bit       clip;
      out_rsp_t exp_rsp;

      // Coefficient load: ignore indexes outside 1..MAX_ORDER
      if (req.func == FUNC_LOAD_COEF) begin
        if (req.coef_index >= 1 && req.coef_index <= MAX_ORDER) begin
          coef_tab[req.coef_index - 1] = req.coef_value;
        end
        return;
      end

      if (req.frame_start) begin
        foreach (history[i]) history[i] = '0;
        hist_ptr = '0;
      end

      // Feedback over the most recent outputs, order limited to MAX_ORDER
      clip = 1'b0;
      taps = (order > MAX_ORDER) ? MAX_ORDER : order;
      acc  = longint'(req.sample) * 64'sd4096;
      for (int k = 1; k <= taps; k++) begin
        acc -= longint'(coef_tab[k - 1]) *
               longint'(history[(int'(hist_ptr) + MAX_ORDER - k) % MAX_ORDER]);
      end
      y = clip16(round_q12(acc), clip);
      history[hist_ptr] = y[15:0];
      hist_ptr++;

      o = clip16(round_q12(longint'(gain) * y), clip);
      exp_rsp.filtered  = o[15:0];
      exp_rsp.saturated = clip;
      expected_outputs.push_back(exp_rsp);
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t exp_rsp;
      if (expected_outputs.size() == 0) begin
        $error("unexpected result: filtered %0d, saturated %0d", got.filtered, got.saturated);
        errors++;
        return;
      end
      exp_rsp = expected_outputs.pop_front();
      if (got.filtered !== exp_rsp.filtered) begin
        $error("filtered: expected %0d, got %0d", exp_rsp.filtered, got.filtered);
        errors++;
      end
      if (got.saturated !== exp_rsp.saturated) begin
        $error("saturated: expected %0d, got %0d", exp_rsp.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_req_t     in_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_rsp_t    out_rsp_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index_i;
  logic [15:0] cfg_data_i;

  filter_scoreboard sb = new();
  bit steady = 1'b0;

  all_pole_synthesis_filter_top #(
    .MAX_ORDER(MAX_ORDER)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Check each result mid-cycle; it is taken at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      sb.check_result(out_rsp_o);
    end
  end

  // Stall the result side at random before each result; steady phases never stall
  initial begin : result_sink
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(negedge clk_i); while (out_valid_o !== 1'b1);
      @(posedge clk_i);
    end
  end

  function automatic in_req_t coef_load(int idx, int val);
    in_req_t r;
    r.func        = FUNC_LOAD_COEF;
    r.coef_index  = idx[4:0];
    r.coef_value  = val[15:0];
    r.sample      = 16'($urandom);
    r.frame_start = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic in_req_t sample_item(int val, bit fs);
    in_req_t r;
    r.func        = FUNC_FILTER;
    r.coef_index  = 5'($urandom);
    r.coef_value  = 16'($urandom);
    r.sample      = val[15:0];
    r.frame_start = fs;
    return r;
  endfunction

  // Present one request after a random gap (none in steady phases) and hold it until taken
  task automatic send_item(in_req_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(negedge clk_i); while (in_stall_o !== 1'b0);
    @(posedge clk_i);
    sb.note_request(r);
  endtask

  // Drop valid and wait until every result is out and the block is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (cfg_ready_o !== 1'b1);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_register(idx, data);
  endtask

  initial begin : stimulus
    int order_pick;
    int gain_pick;
    int shift;
    int roll;
    int v;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FILTER_ORDER;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, zero coefficients: output follows input
    send_item(sample_item(32767, 1'b1));
    send_item(sample_item(-32768, 1'b0));
    send_item(sample_item(0, 1'b0));
    send_item(sample_item(1, 1'b1));

    // Loads to index zero and past the table are dropped
    send_item(coef_load(0, 1234));
    send_item(coef_load(17, -1));
    send_item(coef_load(31, 32767));
    send_item(coef_load(1, -32768));
    send_item(coef_load(16, 32767));
    send_item(coef_load(2, 4096));
    send_item(coef_load(10, -4096));

    // Strong feedback drives the history into saturation
    send_item(sample_item(16384, 1'b1));
    send_item(sample_item(16384, 1'b0));
    send_item(sample_item(-32768, 1'b0));
    send_item(sample_item(100, 1'b0));

    // Mild first coefficient, decaying from a fresh frame
    send_item(coef_load(1, 2048));
    send_item(sample_item(32767, 1'b1));
    send_item(sample_item(0, 1'b0));
    send_item(sample_item(-1, 1'b1));

    // Order zero with maximum gain
    drain();
    write_reg(CFG_FILTER_ORDER, 16'd0);
    write_reg(CFG_OUTPUT_GAIN, 16'hFFFF);
    send_item(sample_item(32767, 1'b0));
    send_item(sample_item(3, 1'b0));

    // Order above the table size, zero gain
    drain();
    write_reg(CFG_FILTER_ORDER, 16'hFFFF);
    write_reg(CFG_OUTPUT_GAIN, 16'd0);
    send_item(sample_item(-20000, 1'b0));
    send_item(sample_item(12345, 1'b0));

    // Random phases, each with fresh settings and coefficients
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      steady = (phase % 3 == 1);
      case (phase)
        0:       order_pick = 16;
        1:       order_pick = 1;
        2:       order_pick = 0;
        3:       order_pick = $urandom_range(17, 31);
        default: order_pick = $urandom_range(1, 16);
      endcase
      case (phase)
        0:       gain_pick = 4096;
        1:       gain_pick = 65535;
        2:       gain_pick = 0;
        3:       gain_pick = 8192;
        default: gain_pick = $urandom_range(0, 65535);
      endcase
      write_reg(CFG_FILTER_ORDER, {11'($urandom), 5'(order_pick)});
      write_reg(CFG_OUTPUT_GAIN, 16'(gain_pick));

      // Coefficient scale: small values keep the loop stable
      case ($urandom_range(0, 3))
        0:       shift = 0;
        1:       shift = 3;
        2:       shift = 5;
        default: shift = 7;
      endcase
      for (int k = 1; k <= MAX_ORDER; k++) begin
        v = $urandom_range(0, 65535) - 32768;
        send_item(coef_load(k, v >>> shift));
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          v = $urandom_range(0, 65535) - 32768;
          send_item(coef_load($urandom_range(0, 31), v >>> shift));
        end else begin
          send_item(sample_item($urandom_range(0, 65535) - 32768, roll < 14));
        end
      end
    end

    steady = 1'b0;
    drain();
    if (sb.errors == 0) begin
      $display("all_pole_synthesis_filter_top_tb: clean");
    end else begin
      $display("all_pole_synthesis_filter_top_tb: errors");
    end
    $finish;
  end

  // Hard limit in case the block hangs
  initial begin : watchdog
    #10_000_000;
    $display("all_pole_synthesis_filter_top_tb: errors");
    $finish;
  end

endmodule
